// ===== hdl/lspc_pkg.sv =====
// Shared constants, codes, state and handshake types for the leaf split-point chooser.
// No dependencies; every other file in hdl/ imports this package.
package lspc_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int SUM_W       = 24;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 16;
  localparam int VAL_W       = 16;
  localparam int UB_W        = 16;
  localparam int OVH_W       = 8;
  localparam int FP_W        = 18;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int STATUS_W    = 2;

  localparam logic [SUM_W-1:0] SUM_MAX          = {SUM_W{1'b1}};
  localparam logic [UB_W-1:0]  USABLE_RESET     = UB_W'(4064);
  localparam logic [OVH_W-1:0] OVERHEAD_RESET   = OVH_W'(8);

  typedef enum logic [STATUS_W-1:0] {
    SPLIT_CHOSEN = 2'd0,
    SPLIT_FEW    = 2'd1,
    SPLIT_NONE   = 2'd2
  } split_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_BYTES      = 1'b0,
    REG_RECORD_OVERHEAD = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lspc_state_t;

  typedef struct packed {
    logic load_en;
    logic scan_start;
    logic scan_issue;
    logic finish;
  } lspc_cmd_t;

  typedef struct packed {
    logic last_in;
    logic short_or_tail;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } lspc_stat_t;

endpackage

// ===== hdl/leaf_split_point_chooser_core.sv =====
// Top level of the leaf split-point chooser: ties controller and datapath together.
// Depends on lspc_pkg, lspc_ctrl and lspc_dp.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+----------------------------------------
//  in_     | in        | in_valid / in_ready     | key and value length, tail cut, last
//  out_    | out       | out_valid / out_ready   | split index/status, total, flags, count
//  cfg_    | in        | cfg_valid / cfg_ready   | register index, write data
//
// Flow: one record word per cycle while loading. After the last word, one evaluate
// state; tail-heavy or short leaves then go straight to finishing. Otherwise the scan
// reads the prefix-sum memory once per candidate split (single read port), then drains
// the two-stage compare pipeline and the best-split update before finishing.
// Reset: rst_n is synchronous; it clears the count, the total, the state machine and
// the output valid flag, and restores the config defaults. The memory needs no clear.
// Stalls: in_ready drops from the last word until the result is moved into the output
// register; a result that waits on out_ready holds the block only when the next leaf
// has finished too. cfg_ready stays high.
module leaf_split_point_chooser_core
  import lspc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_W-1:0]      in_key_length,
  input  logic [VAL_W-1:0]      in_value_length,
  input  logic                  in_tail_cut,
  input  logic                  in_last_record,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CNT_W-1:0]      out_split_index,
  output logic [STATUS_W-1:0]   out_split_status,
  output logic [SUM_W-1:0]      out_total_bytes,
  output logic                  out_fits_page,
  output logic                  out_underfull,
  output logic [CNT_W-1:0]      out_record_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lspc_cmd_t  cmd;
  lspc_stat_t stat;

  // Sequence loading, scanning and result hand-off.
  lspc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold prefix sums, run the scan, hold the result word.
  lspc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_key_length    (in_key_length),
    .in_value_length  (in_value_length),
    .in_tail_cut      (in_tail_cut),
    .in_last_record   (in_last_record),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_split_index  (out_split_index),
    .out_split_status (out_split_status),
    .out_total_bytes  (out_total_bytes),
    .out_fits_page    (out_fits_page),
    .out_underfull    (out_underfull),
    .out_record_count (out_record_count)
  );

  assign in_ready  = cmd.load_en;
  assign cfg_ready = 1'b1;

`ifndef ASSERT_OFF
  a_chosen_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_split_status == SPLIT_CHOSEN) |->
      (out_split_index != '0 && out_split_index < out_record_count))
    else $error("chosen split outside the leaf");

  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_split_status == SPLIT_FEW) |->
      (out_split_index == '0 && out_record_count < CNT_W'(2)))
    else $error("short leaf reported a split");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_split_status == SPLIT_NONE) |-> out_split_index == '0)
    else $error("failed split carries an index");

  a_fits_under: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_underfull) |-> out_fits_page)
    else $error("underfull leaf flagged as not fitting");
`endif

endmodule

// ===== hdl/lspc_ctrl.sv =====
// Controller state machine: record loading, split scan sequencing and result hand-off.
// Depends on lspc_pkg for the state enum and the command/status structs.
module lspc_ctrl
  import lspc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lspc_stat_t stat,
  output lspc_cmd_t  cmd
);

  lspc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (stat.last_in) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.short_or_tail) state_nxt = ST_FINISH;
        else                    state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_LOAD:   cmd.load_en    = 1'b1;
      ST_EVAL:   cmd.scan_start = !stat.short_or_tail;
      ST_SCAN:   cmd.scan_issue = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_FINISH: cmd.finish     = stat.out_free;
      default:   cmd = '0;
    endcase
  end

`ifndef ASSERT_OFF
  // Records are taken only while loading.
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en |-> state_r == ST_LOAD)
    else $error("load enabled outside loading");

  // Scan reads never overlap the result hand-off.
  a_issue_not_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_issue && cmd.finish))
    else $error("scan read issued while finishing");

  // A last record always leads into evaluation.
  a_last_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && stat.last_in) |=> state_r == ST_EVAL)
    else $error("last record did not start evaluation");
`endif

endmodule

// ===== hdl/lspc_dp.sv =====
// Datapath: config registers, prefix-sum memory, saturating accumulator, split scan
// pipeline and output register. Depends on lspc_pkg; driven by lspc_ctrl commands.
module lspc_dp
  import lspc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  lspc_cmd_t             cmd,
  output lspc_stat_t            stat,
  input  logic                  in_valid,
  input  logic [KEY_W-1:0]      in_key_length,
  input  logic [VAL_W-1:0]      in_value_length,
  input  logic                  in_tail_cut,
  input  logic                  in_last_record,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CNT_W-1:0]      out_split_index,
  output logic [STATUS_W-1:0]   out_split_status,
  output logic [SUM_W-1:0]      out_total_bytes,
  output logic                  out_fits_page,
  output logic                  out_underfull,
  output logic [CNT_W-1:0]      out_record_count
);

  logic [UB_W-1:0]  usable_r;
  logic [OVH_W-1:0] overhead_r;
  logic [SUM_W-1:0] total_r;
  logic [CNT_W-1:0] count_r;
  logic             tail_r;

  logic [SUM_W-1:0] mem [MAX_RECORDS];
  logic [SUM_W-1:0] rdata_r;

  logic [ADDR_W-1:0] rd_ptr_r;
  logic              v1_r, v2_r, ok2_r;
  logic [CNT_W-1:0]  idx1_r, idx2_r;
  logic [SUM_W-1:0]  diff2_r;
  logic              found_r;
  logic [SUM_W-1:0]  best_r;
  logic [CNT_W-1:0]  best_idx_r;

  logic                out_valid_r;
  logic [CNT_W-1:0]    idx_out_r;
  split_status_t       status_out_r;
  logic [SUM_W-1:0]    total_out_r;
  logic                fits_out_r, under_out_r;
  logic [CNT_W-1:0]    count_out_r;

  logic [FP_W-1:0]    footprint;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   total_add;
  logic               accept, room;
  logic [SUM_W-1:0]   usable_ext, right, diff;
  logic               ok;
  logic               short_cnt;
  split_status_t      status_nxt;
  logic [CNT_W-1:0]   idx_nxt;

  // Footprint and saturating running total.
  always_comb begin
    footprint = FP_W'(overhead_r) + FP_W'(in_key_length) + FP_W'(in_value_length);
    sum_wide  = (SUM_W + 1)'(total_r) + (SUM_W + 1)'(footprint);
    total_add = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    accept    = cmd.load_en && in_valid;
    room      = count_r != CNT_W'(MAX_RECORDS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r   <= USABLE_RESET;
      overhead_r <= OVERHEAD_RESET;
      total_r    <= '0;
      count_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PAGE_BYTES:      usable_r   <= cfg_data[UB_W-1:0];
          REG_RECORD_OVERHEAD: overhead_r <= cfg_data[OVH_W-1:0];
          default:             usable_r   <= usable_r;
        endcase
      end
      if (accept && room) begin
        total_r <= total_add;
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        total_r <= '0;
        count_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) tail_r <= in_tail_cut;
  end

  // Prefix-sum memory: one write port while loading, one registered read while scanning.
  always_ff @(posedge clk) begin
    if (accept && room) mem[count_r[ADDR_W-1:0]] <= total_add;
    if (cmd.scan_issue) rdata_r <= mem[rd_ptr_r];
  end

  // Stage 2: size both halves and check fit.
  always_comb begin
    usable_ext = SUM_W'(usable_r);
    right      = total_r - rdata_r;
    ok         = (rdata_r <= usable_ext) && (right <= usable_ext);
    diff       = (rdata_r > right) ? (rdata_r - right) : (right - rdata_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
      if (cmd.scan_start || cmd.finish) begin
        found_r <= 1'b0;
      end else if (v2_r && ok2_r && (!found_r || diff2_r < best_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_ptr_r <= '0;
    end else if (cmd.scan_issue) begin
      rd_ptr_r <= rd_ptr_r + ADDR_W'(1);
    end
    idx1_r  <= CNT_W'(rd_ptr_r) + CNT_W'(1);
    idx2_r  <= idx1_r;
    ok2_r   <= ok;
    diff2_r <= diff;
    // Strict compare keeps the lowest index on ties.
    if (v2_r && ok2_r && (!found_r || diff2_r < best_r)) begin
      best_r     <= diff2_r;
      best_idx_r <= idx2_r;
    end
  end

  // Result selection.
  always_comb begin
    short_cnt = count_r < CNT_W'(2);
    if (short_cnt) begin
      status_nxt = SPLIT_FEW;
      idx_nxt    = '0;
    end else if (tail_r) begin
      status_nxt = SPLIT_CHOSEN;
      idx_nxt    = count_r - CNT_W'(1);
    end else if (found_r) begin
      status_nxt = SPLIT_CHOSEN;
      idx_nxt    = best_idx_r;
    end else begin
      status_nxt = SPLIT_NONE;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      idx_out_r    <= idx_nxt;
      status_out_r <= status_nxt;
      total_out_r  <= total_r;
      fits_out_r   <= total_r <= usable_ext;
      under_out_r  <= total_r < SUM_W'(usable_r >> 1);
      count_out_r  <= count_r;
    end
  end

  always_comb begin
    stat.last_in       = in_valid && in_last_record;
    stat.short_or_tail = short_cnt || tail_r;
    stat.scan_last     = CNT_W'(rd_ptr_r) + CNT_W'(2) == count_r;
    stat.pipe_busy     = v1_r || v2_r;
    stat.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_split_index  = idx_out_r;
  assign out_split_status = status_out_r;
  assign out_total_bytes  = total_out_r;
  assign out_fits_page    = fits_out_r;
  assign out_underfull    = under_out_r;
  assign out_record_count = count_out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECORDS))
    else $error("record count past capacity");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (best_idx_r != '0 && best_idx_r < count_r))
    else $error("best split index outside loaded records");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken word");
`endif

endmodule
